// ===== hw/rtl/uvs_pkg.sv =====
// ============================================================================
// UV sphere vertex generator package
// Shared constants, control types and the CORDIC arctangent table.
// ============================================================================
`default_nettype none

package uvs_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int COUNT_WIDTH  = 8;

    // Quotients carry one integer bit and 17 fraction bits of i/count.
    localparam int DIV_STEPS = 18;
    localparam int QW        = DIV_STEPS;
    localparam int REM_W     = COUNT_WIDTH + 1;
    localparam int CNT_W     = 5;
    localparam int XW        = 34;
    localparam int PW        = 2 * XW;
    localparam int RND_SHIFT = 60 - (COORD_WIDTH - 1);

    localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032875);
    localparam logic signed [XW-1:0] ONE_Q30  = XW'(1) <<< 30;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_INIT   = 6'b000100,
        S_CORDIC = 6'b001000,
        S_MUL    = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        C_X = 2'd0,
        C_Y = 2'd1,
        C_Z = 2'd2
    } t_coord;

    typedef struct packed {
        logic             start;
        logic             div_step;
        logic             cordic_init;
        logic             cordic_step;
        logic [CNT_W-1:0] step_idx;
        logic             mul;
        t_coord           mul_sel;
        logic             rnd;
        t_coord           rnd_sel;
        logic             load_out;
    } t_cmd;

    // Arctangent of 2^-k in units of 2^-32 turn.
    function automatic logic [31:0] f_atan(input logic [CNT_W-1:0] k);
        logic [31:0] v;
        case (k)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/uvs_ctrl.sv =====
// ============================================================================
// UV sphere vertex generator controller
// Sequences division, CORDIC and multiply phases and owns output valid.
// ============================================================================
`default_nettype none

module uvs_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output uvs_pkg::t_cmd    o_cmd
);
    import uvs_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovalid, n_ovalid;
    logic             w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign w_out_free  = !r_ovalid || i_out_ready;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        o_cmd.step_idx = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = S_DIV;
                    n_cnt   = '0;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.cordic_init = 1'b1;
                n_state = S_CORDIC;
                n_cnt   = '0;
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                end
            end
            S_MUL: begin
                o_cmd.mul     = 1'b1;
                o_cmd.mul_sel = t_coord'(r_cnt[1:0]);
                if (r_cnt != '0) begin
                    o_cmd.rnd     = 1'b1;
                    o_cmd.rnd_sel = t_coord'(r_cnt[1:0] - 2'd1);
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(2)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // Last rounding lands in the result registers; output is loaded once the output register is free.
                if (r_cnt == CNT_W'(3)) begin
                    o_cmd.rnd     = 1'b1;
                    o_cmd.rnd_sel = C_Z;
                    n_cnt = r_cnt + 1'b1;
                end else if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    a_start_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DIV))
        else $error("accepted transaction did not start division");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_ovalid)
        else $error("output load did not raise valid");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> w_out_free)
        else $error("output overwritten while still pending");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CNT_W'(DIV_STEPS)))
        else $error("division step count out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/uvs_datapath.sv =====
// ============================================================================
// UV sphere vertex generator datapath
// Walk registers, two divider lanes, two CORDIC lanes, multiplier and output.
// ============================================================================
`default_nettype none

module uvs_datapath (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  uvs_pkg::t_cmd                              i_cmd,
    input  wire logic                                  i_cfg_we,
    input  wire logic                                  i_cfg_idx,
    input  wire logic [uvs_pkg::COUNT_WIDTH-1:0]       i_cfg_data,
    input  wire logic                                  i_restart,
    output logic signed [uvs_pkg::COORD_WIDTH-1:0]     o_pos_x,
    output logic signed [uvs_pkg::COORD_WIDTH-1:0]     o_pos_y,
    output logic signed [uvs_pkg::COORD_WIDTH-1:0]     o_pos_z,
    output logic [15:0]                                o_tex_u,
    output logic [15:0]                                o_tex_v,
    output logic [15:0]                                o_vertex_number,
    output logic                                       o_last_vertex
);
    import uvs_pkg::*;

    localparam int CW = COUNT_WIDTH;

    logic [CW-1:0]  r_stack_cnt, r_slice_cnt;
    logic [CW-1:0]  r_pos_i, r_pos_j;
    logic [15:0]    r_vcnt;
    logic [15:0]    r_vnum;
    logic           r_last;
    logic [CW-1:0]  w_st, w_sl, w_i, w_j;
    logic           w_clr, w_last;

    logic [REM_W-1:0] r_rem_p, r_rem_t;
    logic [QW-1:0]    r_q_p, r_q_t;

    logic signed [XW-1:0] r_xp, r_yp, r_zp, r_xt, r_yt, r_zt;
    logic                 r_flip_p, r_flip_t;
    logic signed [PW-1:0] r_prod;
    logic signed [COORD_WIDTH-1:0] r_rx, r_ry, r_rz;

    logic [31:0]          w_ang_p, w_ang_t;
    logic signed [XW-1:0] w_sp, w_cp, w_stt, w_ct, w_ma, w_mb;
    logic signed [PW-1:0] w_rsum, w_rsh;
    logic signed [COORD_WIDTH-1:0] w_rval;
    logic [QW-2:0]        w_half_p, w_half_t;

    // A count of zero behaves as one.
    assign w_st = (r_stack_cnt == '0) ? CW'(1) : r_stack_cnt;
    assign w_sl = (r_slice_cnt == '0) ? CW'(1) : r_slice_cnt;

    assign w_clr  = i_restart || (r_pos_i > w_st) || (r_pos_j > w_sl);
    assign w_i    = w_clr ? '0 : r_pos_i;
    assign w_j    = w_clr ? '0 : r_pos_j;
    assign w_last = (w_i == w_st) && (w_j == w_sl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_cnt <= CW'(16);
            r_slice_cnt <= CW'(32);
            r_pos_i     <= '0;
            r_pos_j     <= '0;
            r_vcnt      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx) begin
                    r_slice_cnt <= i_cfg_data;
                end else begin
                    r_stack_cnt <= i_cfg_data;
                end
            end
            if (i_cmd.start) begin
                if (w_last) begin
                    r_pos_i <= '0;
                    r_pos_j <= '0;
                    r_vcnt  <= '0;
                end else begin
                    r_vcnt <= (w_clr ? 16'd0 : r_vcnt) + 16'd1;
                    if (w_j >= w_sl) begin
                        r_pos_j <= '0;
                        r_pos_i <= w_i + 1'b1;
                    end else begin
                        r_pos_j <= w_j + 1'b1;
                        r_pos_i <= w_i;
                    end
                end
            end
        end
    end

    // Restoring division: quotient of position over count with 17 fraction bits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_vnum  <= w_clr ? 16'd0 : r_vcnt;
            r_last  <= w_last;
            r_rem_p <= REM_W'(w_i);
            r_rem_t <= REM_W'(w_j);
            r_q_p   <= '0;
            r_q_t   <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem_p >= REM_W'(w_st)) begin
                r_rem_p <= REM_W'((r_rem_p - REM_W'(w_st)) << 1);
                r_q_p   <= {r_q_p[QW-2:0], 1'b1};
            end else begin
                r_rem_p <= REM_W'(r_rem_p << 1);
                r_q_p   <= {r_q_p[QW-2:0], 1'b0};
            end
            if (r_rem_t >= REM_W'(w_sl)) begin
                r_rem_t <= REM_W'((r_rem_t - REM_W'(w_sl)) << 1);
                r_q_t   <= {r_q_t[QW-2:0], 1'b1};
            end else begin
                r_rem_t <= REM_W'(r_rem_t << 1);
                r_q_t   <= {r_q_t[QW-2:0], 1'b0};
            end
        end
    end

    // Phi uses the code over 2^16, theta over 2^17; both in units of pi/2^16.
    assign w_ang_p = {r_q_p[QW-1:1], 15'd0};
    assign w_ang_t = {r_q_t[QW-2:0], 15'd0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_init) begin
            r_flip_p <= w_ang_p[31] ^ w_ang_p[30];
            r_flip_t <= w_ang_t[31] ^ w_ang_t[30];
            r_zp <= XW'(signed'(w_ang_p ^ {w_ang_p[31] ^ w_ang_p[30], 31'd0}));
            r_zt <= XW'(signed'(w_ang_t ^ {w_ang_t[31] ^ w_ang_t[30], 31'd0}));
            r_xp <= GAIN_Q30;
            r_yp <= '0;
            r_xt <= GAIN_Q30;
            r_yt <= '0;
        end else if (i_cmd.cordic_step) begin
            if (!r_zp[XW-1]) begin
                r_xp <= r_xp - (r_yp >>> i_cmd.step_idx);
                r_yp <= r_yp + (r_xp >>> i_cmd.step_idx);
                r_zp <= r_zp - XW'(f_atan(i_cmd.step_idx));
            end else begin
                r_xp <= r_xp + (r_yp >>> i_cmd.step_idx);
                r_yp <= r_yp - (r_xp >>> i_cmd.step_idx);
                r_zp <= r_zp + XW'(f_atan(i_cmd.step_idx));
            end
            if (!r_zt[XW-1]) begin
                r_xt <= r_xt - (r_yt >>> i_cmd.step_idx);
                r_yt <= r_yt + (r_xt >>> i_cmd.step_idx);
                r_zt <= r_zt - XW'(f_atan(i_cmd.step_idx));
            end else begin
                r_xt <= r_xt + (r_yt >>> i_cmd.step_idx);
                r_yt <= r_yt - (r_xt >>> i_cmd.step_idx);
                r_zt <= r_zt + XW'(f_atan(i_cmd.step_idx));
            end
        end
    end

    // A folded angle negates both sine and cosine.
    assign w_sp  = r_flip_p ? -r_yp : r_yp;
    assign w_cp  = r_flip_p ? -r_xp : r_xp;
    assign w_stt = r_flip_t ? -r_yt : r_yt;
    assign w_ct  = r_flip_t ? -r_xt : r_xt;

    always_comb begin
        case (i_cmd.mul_sel)
            C_X: begin
                w_ma = w_sp;
                w_mb = w_ct;
            end
            C_Y: begin
                w_ma = w_cp;
                w_mb = ONE_Q30;
            end
            C_Z: begin
                w_ma = w_sp;
                w_mb = w_stt;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_rsum = r_prod + (PW'(1) <<< (RND_SHIFT - 1));
    assign w_rsh  = w_rsum >>> RND_SHIFT;

    always_comb begin
        if (w_rsh > PW'((1 << (COORD_WIDTH - 1)) - 1)) begin
            w_rval = COORD_WIDTH'((1 << (COORD_WIDTH - 1)) - 1);
        end else if (w_rsh < -(PW'(1) <<< (COORD_WIDTH - 1))) begin
            w_rval = COORD_WIDTH'(1) <<< (COORD_WIDTH - 1);
        end else begin
            w_rval = w_rsh[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= w_ma * w_mb;
        end
        if (i_cmd.rnd) begin
            case (i_cmd.rnd_sel)
                C_X:     r_rx <= w_rval;
                C_Y:     r_ry <= w_rval;
                C_Z:     r_rz <= w_rval;
                default: r_rz <= w_rval;
            endcase
        end
    end

    // Texture coordinate is the quotient over 2^16 plus one, halved.
    assign w_half_t = r_q_t[QW-1:1] + 1'b1;
    assign w_half_p = r_q_p[QW-1:1] + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_pos_x         <= r_rx;
            o_pos_y         <= r_ry;
            o_pos_z         <= r_rz;
            o_tex_u         <= w_half_t[QW-2:1];
            o_tex_v         <= w_half_p[QW-2:1];
            o_vertex_number <= r_vnum;
            o_last_vertex   <= r_last;
        end
    end

    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start && i_restart) |=> (r_vnum == 16'd0))
        else $error("restart did not return to vertex zero");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start && !i_cfg_we) |=> (r_pos_i <= w_st))
        else $error("stack position left its range");

endmodule

`default_nettype wire

// ===== hw/rtl/uv_sphere_vertex_generator_unit.sv =====
// ============================================================================
// UV sphere vertex generator
// Emits one unit sphere vertex with texture coordinates per transaction.
// ============================================================================
// Each transaction runs the 18-step divider, the 16-step CORDIC and the
// multiply and rounding steps back to back; a new input is accepted only
// after the previous result has been loaded into the output register.
// Synchronous active-low reset returns the walk to vertex zero and restores
// stack count 16 and slice count 32.
`default_nettype none

module uv_sphere_vertex_generator_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic                                  i_cfg_idx,
    input  wire logic [uvs_pkg::COUNT_WIDTH-1:0]       i_cfg_data,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic                                  i_restart,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [uvs_pkg::COORD_WIDTH-1:0]     o_pos_x,
    output logic signed [uvs_pkg::COORD_WIDTH-1:0]     o_pos_y,
    output logic signed [uvs_pkg::COORD_WIDTH-1:0]     o_pos_z,
    output logic [15:0]                                o_tex_u,
    output logic [15:0]                                o_tex_v,
    output logic [15:0]                                o_vertex_number,
    output logic                                       o_last_vertex
);
    import uvs_pkg::*;

    t_cmd w_cmd;

    uvs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    uvs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_restart       (i_restart),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_pos_z         (o_pos_z),
        .o_tex_u         (o_tex_u),
        .o_tex_v         (o_tex_v),
        .o_vertex_number (o_vertex_number),
        .o_last_vertex   (o_last_vertex)
    );

endmodule

`default_nettype wire

// ===== tb/uv_sphere_vertex_generator_unit_tb.sv =====
// ============================================================================
// UV sphere vertex generator testbench
// Walks meshes of many stack and slice counts and checks each vertex against
// an in-bench bit-exact model of the divider, CORDIC and rounding.
// ============================================================================
`default_nettype none

module uv_sphere_vertex_generator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import uvs_pkg::*;

    localparam int IDX_STACK = 0;
    localparam int IDX_SLICE = 1;
    localparam int SHIFT_OUT = 60 - (COORD_WIDTH - 1);

    typedef struct {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic [15:0]                   tex_u;
        logic [15:0]                   tex_v;
        logic [15:0]                   vnum;
        logic                          last;
    } t_vertex;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [COUNT_WIDTH-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_restart = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [COORD_WIDTH-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic [15:0] o_tex_u, o_tex_v, o_vertex_number;
    logic o_last_vertex;

    uv_sphere_vertex_generator_unit dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Model state.
    logic [COUNT_WIDTH-1:0] stacks_m, slices_m, stack_pos, slice_pos;
    logic [15:0] vcount;
    t_vertex vertex_q[$];
    int errors = 0;
    int tx_idle = 0;
    int rx_idle = 0;

    const logic [31:0] atan_tab[16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

    task automatic sin_cos(input logic [31:0] ang, output longint s, output longint c);
        bit flip;
        longint x, y, z, nx;
        logic [31:0] a, t;
        a = ang;
        t = a + 32'h40000000;
        flip = t[31];
        if (flip) a = a + 32'h80000000;
        z = longint'($signed(a));
        x = 652032875;
        y = 0;
        for (int k = 0; k < CORDIC_STEPS && k < 16; k++) begin
            if (z >= 0) begin
                nx = x - (y >>> k);
                y = y + (x >>> k);
                z = z - longint'(atan_tab[k]);
            end else begin
                nx = x + (y >>> k);
                y = y - (x >>> k);
                z = z + longint'(atan_tab[k]);
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] q60_to_coord(longint a, longint b);
        longint r;
        r = (a * b + (longint'(1) <<< (SHIFT_OUT - 1))) >>> SHIFT_OUT;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[COORD_WIDTH-1:0];
    endfunction

    task automatic next_vertex(input bit restart, output t_vertex v);
        longint st, sl, i, j, phi, th, sp, cp, sth, cth;
        logic [31:0] ang;
        st = (stacks_m == 0) ? 1 : stacks_m;
        sl = (slices_m == 0) ? 1 : slices_m;
        // A count lowered mid-walk sends the walk back to vertex zero.
        if (restart || stack_pos > st || slice_pos > sl) begin
            stack_pos = '0;
            slice_pos = '0;
            vcount = '0;
        end
        i = stack_pos;
        j = slice_pos;
        phi = (i << 16) / st;
        th = (j << 17) / sl;
        ang = 32'(phi << 15);
        sin_cos(ang, sp, cp);
        ang = 32'(th << 15);
        sin_cos(ang, sth, cth);
        v.pos_x = q60_to_coord(sp, cth);
        v.pos_y = q60_to_coord(cp, longint'(1) << 30);
        v.pos_z = q60_to_coord(sp, sth);
        v.tex_u = 16'((j * 65536 + sl) / (2 * sl));
        v.tex_v = 16'((i * 65536 + st) / (2 * st));
        v.vnum = vcount;
        v.last = (i == st) && (j == sl);
        if (v.last) begin
            stack_pos = '0;
            slice_pos = '0;
            vcount = '0;
        end else begin
            vcount = vcount + 16'd1;
            if (j >= sl) begin
                slice_pos = '0;
                stack_pos = stack_pos + 1'b1;
            end else begin
                slice_pos = slice_pos + 1'b1;
            end
        end
    endtask

    // Drives one transaction; valid stays high on return so back-to-back
    // items never see it lowered and raised in one step.
    task automatic send_vertex_req(input bit restart);
        t_vertex v;
        if ($urandom_range(99) < tx_idle) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (!o_in_ready);
        next_vertex(restart, v);
        vertex_q = {vertex_q, v};
    endtask

    task automatic drain_vertices();
        i_in_valid <= 1'b0;
        i_restart <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_counts(input logic [COUNT_WIDTH-1:0] st,
                                input logic [COUNT_WIDTH-1:0] sl);
        drain_vertices();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= IDX_STACK[0];
        i_cfg_data <= st;
        @(posedge i_clk);
        i_cfg_idx <= IDX_SLICE[0];
        i_cfg_data <= sl;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        stacks_m = st;
        slices_m = sl;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (vertex_q.size() == 0) begin
                $error("unexpected vertex %0d", o_vertex_number);
                errors++;
            end else begin
                e = vertex_q.pop_front();
                if (o_pos_x !== e.pos_x) begin
                    $error("pos_x exp %0d got %0d", e.pos_x, o_pos_x); errors++;
                end
                if (o_pos_y !== e.pos_y) begin
                    $error("pos_y exp %0d got %0d", e.pos_y, o_pos_y); errors++;
                end
                if (o_pos_z !== e.pos_z) begin
                    $error("pos_z exp %0d got %0d", e.pos_z, o_pos_z); errors++;
                end
                if (o_tex_u !== e.tex_u) begin
                    $error("tex_u exp %0d got %0d", e.tex_u, o_tex_u); errors++;
                end
                if (o_tex_v !== e.tex_v) begin
                    $error("tex_v exp %0d got %0d", e.tex_v, o_tex_v); errors++;
                end
                if (o_vertex_number !== e.vnum) begin
                    $error("vertex_number exp %0d got %0d", e.vnum, o_vertex_number);
                    errors++;
                end
                if (o_last_vertex !== e.last) begin
                    $error("last_vertex exp %0d got %0d", e.last, o_last_vertex);
                    errors++;
                end
            end
        end
    end

    task automatic test_reset_counts();
        repeat (20) send_vertex_req(1'b0);
        send_vertex_req(1'b1);
    endtask

    task automatic test_count_extremes();
        write_counts(8'd1, 8'd1);
        repeat (5) send_vertex_req(1'b0);
        write_counts(8'd0, 8'd0);
        repeat (5) send_vertex_req(1'b0);
        write_counts(8'd255, 8'd255);
        send_vertex_req(1'b1);
        repeat (4) send_vertex_req(1'b0);
        // Lowering the counts mid-walk sends the walk back to zero.
        write_counts(8'd2, 8'd2);
        repeat (5) send_vertex_req(1'b0);
    endtask

    task automatic test_random_meshes(input int n_items);
        int done;
        done = 0;
        while (done < n_items) begin
            case ($urandom_range(3))
                0: write_counts(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)));
                1: write_counts(8'($urandom_range(255)), 8'($urandom_range(1, 4)));
                2: write_counts(8'($urandom_range(1, 4)), 8'($urandom_range(255)));
                default: write_counts(8'($urandom), 8'($urandom));
            endcase
            repeat ($urandom_range(10, 60)) begin
                send_vertex_req($urandom_range(99) < 4);
                done++;
            end
        end
    endtask

    initial begin
        stacks_m = 8'd16;
        slices_m = 8'd32;
        stack_pos = '0;
        slice_pos = '0;
        vcount = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle = 13;
        rx_idle = 76;
        test_reset_counts();
        test_count_extremes();
        test_random_meshes(250);
        tx_idle = 76;
        rx_idle = 13;
        test_random_meshes(250);
        tx_idle = 0;
        rx_idle = 0;
        test_random_meshes(250);
        drain_vertices();
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/uvs_pkg.sv
hw/rtl/uvs_ctrl.sv
hw/rtl/uvs_datapath.sv
hw/rtl/uv_sphere_vertex_generator_unit.sv
tb/uv_sphere_vertex_generator_unit_tb.sv
